>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hdl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Types, codes and default report table of the housekeeping scheduler.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int REPORT_COUNT_DEF = 8;
  localparam int MAX_PARAMS_DEF   = 8;
  localparam int STORE_DEPTH_DEF  = 32;
  localparam int MAX_RESULTS      = 64;

  localparam int BASE_W = 8;  // running list offset, up to 16 slots x 8
  localparam int RUN_W  = 7;  // result count per tick, up to MAX_RESULTS

  localparam logic [1:0] CMD_TC    = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_STORE = 2'd2;

  localparam logic [7:0] SUB_ENABLE   = 8'd5;
  localparam logic [7:0] SUB_DISABLE  = 8'd6;
  localparam logic [7:0] SUB_INTERVAL = 8'd31;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [15:0] EXTRA_ID  = 16'hFFFF;
  localparam logic [15:0] EXTRA_IVL = 16'd60;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] rid;
    logic [4:0]  pid;
    logic [63:0] value;
    logic        has_value;
    logic        last_rep;
  } item_t;

  typedef struct packed {
    logic       wr_en;
    logic [4:0] wr_index;
    logic       rd_en;
    logic [4:0] rd_index;
  } store_req_t;

  function automatic logic [15:0] dflt_id(input logic [3:0] s);
    logic [15:0] v;
    unique case (s)
      4'd0:    v = 16'd0;
      4'd1:    v = 16'd10;
      4'd2:    v = 16'd11;
      4'd3:    v = 16'd100;
      4'd4:    v = 16'd110;
      4'd5:    v = 16'd120;
      4'd6:    v = 16'd200;
      4'd7:    v = 16'd210;
      default: v = EXTRA_ID;
    endcase
    return v;
  endfunction

  function automatic logic dflt_en(input logic [3:0] s);
    logic v;
    unique case (s)
      4'd0, 4'd1, 4'd2: v = 1'b1;
      default:          v = 1'b0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] dflt_ivl(input logic [3:0] s);
    logic [15:0] v;
    unique case (s)
      4'd0:    v = 16'd10;
      4'd1:    v = 16'd30;
      default: v = EXTRA_IVL;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] dflt_cnt(input logic [3:0] s);
    logic [3:0] v;
    unique case (s)
      4'd0, 4'd1:                         v = 4'd4;
      4'd2:                               v = 4'd5;
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7:       v = 4'd2;
      default:                            v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hdl/hrs_param_store.sv
// ----------------------------------------------------------------------------
// hrs_param_store
// Parameter value memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hrs_param_store import hrs_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  store_req_t  req,
  input  logic [63:0] wr_data,
  output logic [63:0] rd_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [63:0]            mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [63:0]            rd_q;
  logic                   rd_ok;
  logic                   wr_hit;
  logic                   rd_hit;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;

  // indices past the depth: writes dropped, reads give zero
  assign wr_hit  = req.wr_en && (32'(req.wr_index) < 32'(STORE_DEPTH));
  assign rd_hit  = 32'(req.rd_index) < 32'(STORE_DEPTH);
  assign wr_addr = AW'(req.wr_index);
  assign rd_addr = AW'(req.rd_index);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_hit) begin
        valid[wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_ok <= rd_hit && valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : 64'd0;

endmodule

>>> hdl/housekeeping_report_scheduler_unit.sv
// ----------------------------------------------------------------------------
// housekeeping_report_scheduler_unit
// Housekeeping report table: telecommand control, periodic report emission.
// ----------------------------------------------------------------------------
// One input transfer is handled at a time. A store write goes straight to the
// parameter memory. A telecommand reads its slot entry, then writes it back
// with the acknowledgement. A tick walks the slot memory slot by slot; each
// fired report emits its parameters (one parameter memory read each) or one
// empty report item, and a closing step ends the run. The walk waits while
// the output side stalls. A result waits in a one-item holding register so
// last_of_run can be set on the final one; the output register lets the next
// input transfer in while it is held. Results past 64 per tick are dropped,
// but counters still advance and clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module housekeeping_report_scheduler_unit import hrs_pkg::*; #(
  parameter int REPORT_COUNT          = REPORT_COUNT_DEF,
  parameter int MAX_PARAMS_PER_REPORT = MAX_PARAMS_DEF,
  parameter int STORE_DEPTH           = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [7:0]  subservice,
  input  logic [15:0] report_id,
  input  logic [15:0] new_interval,
  input  logic [4:0]  store_index,
  input  logic [63:0] store_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] out_report_id,
  output logic [4:0]  param_id,
  output logic [63:0] param_value,
  output logic        has_value,
  output logic        last_of_report,
  output logic        last_of_run
);

  localparam int SW = (REPORT_COUNT > 1) ? $clog2(REPORT_COUNT) : 1;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_TC       = 3'd1;
  localparam logic [2:0] ST_TK_RD    = 3'd2;
  localparam logic [2:0] ST_TK_PAR   = 3'd3;
  localparam logic [2:0] ST_TK_EMPTY = 3'd4;
  localparam logic [2:0] ST_TK_END   = 3'd5;

  logic [2:0]              state;
  logic [SW-1:0]           slot;
  logic                    tc_ok;
  logic [7:0]              tc_sub;
  logic [15:0]             tc_ivl;
  logic [BASE_W-1:0]       base;
  logic [3:0]              j;
  logic [RUN_W-1:0]        n;
  logic [REPORT_COUNT-1:0] enabled;

  // slot memory: {interval, tick counter}; valid bits stand for the defaults
  logic [31:0]             slot_mem [REPORT_COUNT];
  logic [REPORT_COUNT-1:0] slot_valid;
  logic [31:0]             slot_rd;
  logic                    slot_re;
  logic [SW-1:0]           slot_raddr;
  logic                    slot_we;
  logic [31:0]             slot_wdata;

  // holding register and output register
  logic                    pend_valid;
  item_t                   pend;
  item_t                   out_item;
  logic                    out_last_run;

  logic                    in_xfer;
  logic                    out_free;
  logic                    can_push;
  logic                    room;
  logic                    stall;
  logic                    hit;
  logic [SW-1:0]           hit_slot;
  logic                    sub_ok;
  logic [31:0]             entry;
  logic [15:0]             cur_ivl;
  logic [15:0]             cur_cnt;
  logic [15:0]             cnt_inc;
  logic                    fire;
  logic [3:0]              dc;
  logic [3:0]              pcount;
  logic                    last_slot;
  logic                    last_par;
  logic [4:0]              p_index;
  logic [4:0]              p_next;
  logic                    produce;
  logic                    advance;
  item_t                   new_item;
  store_req_t              sreq;
  logic [63:0]             store_rd;

  hrs_param_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (sreq),
    .wr_data (store_value),
    .rd_data (store_rd)
  );

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign can_push = !pend_valid || out_free;
  assign room     = n < RUN_W'(MAX_RESULTS);
  assign stall    = room && !can_push;

  assign sub_ok = (subservice == SUB_ENABLE) || (subservice == SUB_DISABLE) ||
                  (subservice == SUB_INTERVAL);

  // id lookup against the fixed id table, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = REPORT_COUNT - 1; i >= 0; i--) begin
      if (dflt_id(4'(i)) == report_id) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  // current slot entry, default until first written
  assign entry     = slot_valid[slot] ? slot_rd : {dflt_ivl(4'(slot)), 16'd0};
  assign cur_ivl   = entry[31:16];
  assign cur_cnt   = entry[15:0];
  assign cnt_inc   = (cur_cnt == 16'hFFFF) ? cur_cnt : cur_cnt + 16'd1;
  assign fire      = cnt_inc >= cur_ivl;

  assign dc        = dflt_cnt(4'(slot));
  assign pcount    = (dc > 4'(MAX_PARAMS_PER_REPORT)) ? 4'(MAX_PARAMS_PER_REPORT) : dc;
  assign last_slot = (slot == SW'(REPORT_COUNT - 1));
  assign last_par  = (j == pcount - 4'd1);

  // list entries are consecutive store indices, offset by the earlier slots
  assign p_index = 5'(base + {4'd0, j});
  assign p_next  = 5'(base + {4'd0, j} + 8'd1);

  // memory strobes and item production
  always_comb begin
    slot_re       = 1'b0;
    slot_raddr    = slot;
    slot_we       = 1'b0;
    slot_wdata    = {cur_ivl, 16'd0};
    sreq          = '0;
    sreq.wr_index = store_index;
    sreq.rd_index = p_index;
    produce       = 1'b0;
    advance       = 1'b0;
    new_item      = '{kind: KIND_REPORT, rid: dflt_id(4'(slot)), pid: p_index,
                      value: store_rd, has_value: 1'b1, last_rep: last_par};
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (cmd == CMD_TC) begin
            slot_re    = hit && sub_ok;
            slot_raddr = hit_slot;
          end else if (cmd == CMD_TICK) begin
            slot_re    = 1'b1;
            slot_raddr = '0;
          end else if (cmd == CMD_STORE) begin
            sreq.wr_en = 1'b1;
          end
        end
      end
      ST_TC: begin
        if (out_free && tc_ok) begin
          slot_we    = 1'b1;
          slot_wdata = (tc_sub == SUB_INTERVAL) ? {tc_ivl, cur_cnt} : {cur_ivl, 16'd0};
        end
      end
      ST_TK_RD: begin
        if (enabled[slot]) begin
          slot_we    = 1'b1;
          slot_wdata = fire ? {cur_ivl, 16'd0} : {cur_ivl, cnt_inc};
          // first parameter read goes out with the write-back
          sreq.rd_en = fire && (pcount != 4'd0);
        end
        advance = !(enabled[slot] && fire);
      end
      ST_TK_PAR: begin
        if (!stall) begin
          produce = room;
          if (last_par) begin
            advance = 1'b1;
          end else begin
            sreq.rd_en    = 1'b1;
            sreq.rd_index = p_next;
          end
        end
      end
      ST_TK_EMPTY: begin
        new_item.pid       = 5'd0;
        new_item.value     = 64'd0;
        new_item.has_value = 1'b0;
        new_item.last_rep  = 1'b1;
        if (!stall) begin
          produce = room;
          advance = 1'b1;
        end
      end
      ST_TK_END: begin
      end
      default: begin
      end
    endcase
    if (advance && !last_slot) begin
      slot_re    = 1'b1;
      slot_raddr = slot + SW'(1);
    end
  end

  // slot memory, one read and one write port
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer && cmd == CMD_TC) begin
      tc_sub <= subservice;
      tc_ivl <= new_interval;
    end
    if (produce) begin
      pend <= new_item;
      if (pend_valid) begin
        out_item <= pend;
      end
    end else if (state == ST_TK_END && pend_valid && out_free) begin
      out_item <= pend;
    end else if (state == ST_TC && out_free) begin
      out_item <= '{kind: tc_ok ? KIND_ACCEPT : KIND_REJECT, rid: 16'd0, pid: 5'd0,
                    value: 64'd0, has_value: 1'b0, last_rep: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot         <= '0;
      tc_ok        <= 1'b0;
      base         <= '0;
      j            <= '0;
      n            <= '0;
      slot_valid   <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      out_last_run <= 1'b0;
      for (int i = 0; i < REPORT_COUNT; i++) begin
        enabled[i] <= dflt_en(4'(i));
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (slot_we) begin
        slot_valid[slot] <= 1'b1;
      end
      // a new item pushes the held one out; it is not the last of the run
      if (produce) begin
        pend_valid <= 1'b1;
        n          <= n + RUN_W'(1);
        if (pend_valid) begin
          out_valid    <= 1'b1;
          out_last_run <= 1'b0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (cmd == CMD_TC) begin
              tc_ok <= hit && sub_ok;
              slot  <= hit_slot;
              state <= ST_TC;
            end else if (cmd == CMD_TICK) begin
              slot  <= '0;
              base  <= '0;
              j     <= '0;
              n     <= '0;
              state <= ST_TK_RD;
            end
          end
        end
        ST_TC: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_last_run <= 1'b1;
            if (tc_ok && tc_sub != SUB_INTERVAL) begin
              enabled[slot] <= (tc_sub == SUB_ENABLE);
            end
            state <= ST_IDLE;
          end
        end
        ST_TK_RD: begin
          if (enabled[slot] && fire) begin
            j     <= '0;
            state <= (pcount == 4'd0) ? ST_TK_EMPTY : ST_TK_PAR;
          end
        end
        ST_TK_PAR: begin
          if (!stall && !last_par) begin
            j <= j + 4'd1;
          end
        end
        ST_TK_EMPTY: begin
        end
        ST_TK_END: begin
          // flush the held item as the final result of the run
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            out_last_run <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (advance) begin
        base <= base + BASE_W'(pcount);
        j    <= '0;
        if (last_slot) begin
          state <= ST_TK_END;
        end else begin
          slot  <= slot + SW'(1);
          state <= ST_TK_RD;
        end
      end
    end
  end

  assign kind           = out_item.kind;
  assign out_report_id  = out_item.rid;
  assign param_id       = out_item.pid;
  assign param_value    = out_item.value;
  assign has_value      = out_item.has_value;
  assign last_of_report = out_item.last_rep;
  assign last_of_run    = out_last_run;

  // holding register is always drained before the block goes idle
  `ASSERT_IMPLIES(a_idle_no_pend, clk, rst, state == ST_IDLE, !pend_valid)
  // only a tick run holds an item back
  `ASSERT_IMPLIES(a_pend_in_tick, clk, rst, pend_valid, (state != ST_IDLE) && (state != ST_TC))
  // result budget per tick
  `ASSERT_IMPLIES(a_budget, clk, rst, state != ST_IDLE, n <= RUN_W'(MAX_RESULTS))
  // a produced item lands in the holding register
  `ASSERT_NEXT(a_produce_held, clk, rst, produce, pend_valid)
  // a tick transfer starts the slot walk
  `ASSERT_NEXT(a_tick_walk, clk, rst, in_xfer && (cmd == CMD_TICK), state == ST_TK_RD)

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the housekeeping report scheduler: a local model of
// the report table predicts acknowledgements and report items per transfer,
// while random idle bursts, a long output hold-off and mixed traffic run.
// ----------------------------------------------------------------------------
module testbench import hrs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = 8;
  localparam int PARAMS     = 8;
  localparam int DEPTH      = 32;
  localparam int RESULT_CAP = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_TAIL    = 60;
  localparam int HOLD_AT      = 200;   // transfers in before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;

  // codes the block has no name for
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [7:0] SUB_BOGUS  = 8'd7;
  localparam logic [7:0] SUB_TOP    = 8'd255;
  localparam logic [7:0] SUB_ZERO   = 8'd0;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] rid;
    logic [4:0]  pid;
    logic [63:0] value;
    logic        has_value;
    logic        last_rep;
    logic        last_run;
  } hk_item_t;

  // report table model plus the queue of items still owed by the block
  class hk_schedule_tracker;
    bit          enabled[SLOTS];
    logic [15:0] interval[SLOTS];
    logic [15:0] ticks[SLOTS];
    logic [15:0] ids[SLOTS];
    logic [3:0]  nparams[SLOTS];
    logic [4:0]  plist[SLOTS*PARAMS];
    logic [63:0] store[DEPTH];
    hk_item_t    awaited_items[$];
    int unsigned errors, taken, n_tc, n_tick, n_store, n_acks, n_reports;

    function new();
      logic [15:0] id_tab[SLOTS];
      logic [15:0] ivl_tab[SLOTS];
      logic [3:0]  cnt_tab[SLOTS];
      int next;
      id_tab  = '{16'd0, 16'd10, 16'd11, 16'd100, 16'd110, 16'd120, 16'd200, 16'd210};
      ivl_tab = '{16'd10, 16'd30, 16'd60, 16'd60, 16'd60, 16'd60, 16'd60, 16'd60};
      cnt_tab = '{4'd4, 4'd4, 4'd5, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
      next = 0;
      foreach (store[i]) store[i] = '0;
      foreach (plist[i]) plist[i] = '0;
      for (int r = 0; r < SLOTS; r++) begin
        ids[r]      = id_tab[r];
        enabled[r]  = (r < 3);
        interval[r] = ivl_tab[r];
        ticks[r]    = '0;
        nparams[r]  = (cnt_tab[r] > PARAMS) ? 4'(PARAMS) : cnt_tab[r];
        for (int j = 0; j < nparams[r]; j++) begin
          plist[r*PARAMS+j] = 5'(next);
          next++;
        end
      end
    endfunction

    function automatic hk_item_t make(logic [1:0] k, logic [15:0] rid, logic [4:0] pid,
                                      logic [63:0] v, logic hv, logic lr);
      hk_item_t it;
      it.kind = k; it.rid = rid; it.pid = pid; it.value = v;
      it.has_value = hv; it.last_rep = lr; it.last_run = 1'b0;
      return it;
    endfunction

    // one accepted input transfer: update the table, queue what it causes
    function void take_command(logic [1:0] cmd, logic [7:0] sub, logic [15:0] rid,
                               logic [15:0] nivl, logic [4:0] sidx, logic [63:0] sval);
      hk_item_t fired[$];
      int slot, n;
      bit ok;
      logic [4:0] p;
      taken++;
      case (cmd)
        CMD_TC: begin
          n_tc++;
          slot = -1;
          for (int r = SLOTS - 1; r >= 0; r--) if (ids[r] == rid) slot = r;
          ok = 1'b0;
          if (slot >= 0) begin
            if (sub == SUB_ENABLE || sub == SUB_DISABLE) begin
              enabled[slot] = (sub == SUB_ENABLE);
              ticks[slot] = '0;
              ok = 1'b1;
            end else if (sub == SUB_INTERVAL) begin
              interval[slot] = nivl;
              ok = 1'b1;
            end
          end
          fired.push_back(make(ok ? KIND_ACCEPT : KIND_REJECT, '0, '0, '0, 1'b0, 1'b0));
        end
        CMD_TICK: begin
          n_tick++;
          for (int r = 0; r < SLOTS; r++) begin
            if (!enabled[r]) continue;
            if (ticks[r] != 16'hFFFF) ticks[r]++;
            if (ticks[r] < interval[r]) continue;
            ticks[r] = '0;
            n = (nparams[r] > PARAMS) ? PARAMS : nparams[r];
            if (n == 0) begin
              if (fired.size() < RESULT_CAP)
                fired.push_back(make(KIND_REPORT, ids[r], '0, '0, 1'b0, 1'b1));
              continue;
            end
            for (int j = 0; j < n; j++) begin
              p = plist[r*PARAMS+j];
              if (fired.size() < RESULT_CAP)
                fired.push_back(make(KIND_REPORT, ids[r], p,
                                     (p < DEPTH) ? store[p] : 64'd0, 1'b1, (j == n - 1)));
            end
          end
        end
        CMD_STORE: begin
          n_store++;
          if (sidx < DEPTH) store[sidx] = sval;
        end
        default: ;
      endcase
      if (fired.size() > 0) fired[$].last_run = 1'b1;
      foreach (fired[i]) awaited_items.push_back(fired[i]);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // one accepted output transfer against the oldest owed item
    task match_output(hk_item_t got);
      hk_item_t exp_it;
      if (awaited_items.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %0d", got.kind, got.rid));
        return;
      end
      exp_it = awaited_items.pop_front();
      if (exp_it.kind == KIND_REPORT) n_reports++; else n_acks++;
      if (got.kind !== exp_it.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, exp_it.kind));
      if (got.rid !== exp_it.rid)
        report_mismatch($sformatf("report id %0d, want %0d", got.rid, exp_it.rid));
      if (got.pid !== exp_it.pid)
        report_mismatch($sformatf("param id %0d, want %0d", got.pid, exp_it.pid));
      if (got.value !== exp_it.value)
        report_mismatch($sformatf("param value %h, want %h", got.value, exp_it.value));
      if (got.has_value !== exp_it.has_value)
        report_mismatch($sformatf("has_value %b, want %b", got.has_value, exp_it.has_value));
      if (got.last_rep !== exp_it.last_rep)
        report_mismatch($sformatf("last_of_report %b, want %b", got.last_rep,
                                  exp_it.last_rep));
      if (got.last_run !== exp_it.last_run)
        report_mismatch($sformatf("last_of_run %b, want %b", got.last_run, exp_it.last_run));
    endtask

    function int outstanding();
      return awaited_items.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid, in_ready;
  logic [1:0]  cmd;
  logic [7:0]  subservice;
  logic [15:0] report_id, new_interval;
  logic [4:0]  store_index;
  logic [63:0] store_value;
  logic        out_valid, out_ready;
  logic [1:0]  kind;
  logic [15:0] out_report_id;
  logic [4:0]  param_id;
  logic [63:0] param_value;
  logic        has_value, last_of_report, last_of_run;

  hk_schedule_tracker tracker = new();
  bit          calm;        // no idling on either side once set
  bit          tx_gappy;
  int unsigned cycles;

  housekeeping_report_scheduler_unit uut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .subservice, .report_id, .new_interval,
    .store_index, .store_value, .out_valid, .out_ready, .kind, .out_report_id,
    .param_id, .param_value, .has_value, .last_of_report, .last_of_run
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("housekeeping_report_scheduler_unit regression: fail");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off mid-run
  initial begin : result_sink
    int  stall_left;
    bit  held, rx_gappy;
    stall_left = 0;
    held = 1'b0;
    rx_gappy = 1'b1;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.match_output('{kind, out_report_id, param_id, param_value, has_value,
                               last_of_report, last_of_run});
      if (cycles % 256 == 0) rx_gappy = ($urandom_range(0, 2) != 0);
      if (!held && tracker.taken >= HOLD_AT) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && rx_gappy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // hold the item until transferred, then hand it to the model
  task automatic offer(logic [1:0] c, logic [7:0] s, logic [15:0] r, logic [15:0] iv,
                       logic [4:0] si, logic [63:0] sv);
    if (!calm && tx_gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c; subservice <= s; report_id <= r; new_interval <= iv;
    store_index <= si; store_value <= sv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_command(c, s, r, iv, si, sv);
  endtask

  task automatic tc(logic [7:0] s, logic [15:0] r, logic [15:0] iv);
    offer(CMD_TC, s, r, iv, 5'($urandom_range(0, 31)), {$urandom, $urandom});
  endtask

  task automatic tick();
    offer(CMD_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
          16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)), {$urandom, $urandom});
  endtask

  task automatic put_store(logic [4:0] si, logic [63:0] sv);
    offer(CMD_STORE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
          16'($urandom_range(0, 65535)), si, sv);
  endtask

  // ticks, store writes and mostly well-formed telecommands on known ids with short intervals
  task automatic random_item();
    logic [7:0]  s;
    logic [15:0] r, iv;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      tick();
    end else if (pick < 70) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: s = SUB_ENABLE;
        4, 5:       s = SUB_DISABLE;
        6, 7, 8:    s = SUB_INTERVAL;
        default:    s = 8'($urandom_range(0, 255));
      endcase
      r = ($urandom_range(0, 6) != 0) ? tracker.ids[$urandom_range(0, SLOTS - 1)]
                                      : 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
        0:       iv = 16'($urandom_range(0, 65535));
        1, 2:    iv = 16'($urandom_range(0, 40));
        default: iv = 16'($urandom_range(0, 6));
      endcase
      tc(s, r, iv);
    end else begin
      put_store(5'($urandom_range(0, 31)), {$urandom, $urandom});
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_STORE; subservice <= '0; report_id <= '0; new_interval <= '0;
    store_index <= '0; store_value <= '0;
    calm = 1'b0;
    tx_gappy = 1'b1;
    cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: store extremes, every subservice, rejects, interval zero,
    // interval lowered below a running count, undefined command
    put_store(5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    put_store(5'd31, {$urandom, $urandom});
    put_store(5'd4, 64'hAAAA_5555_AAAA_5555);
    tc(SUB_INTERVAL, tracker.ids[0], 16'd0);       // fires on every tick
    tick();
    tc(SUB_BOGUS, tracker.ids[0], 16'd0);
    tc(SUB_TOP, tracker.ids[1], 16'd0);
    tc(SUB_ZERO, tracker.ids[1], 16'd0);
    tc(SUB_ENABLE, 16'hFFFF, 16'd0);               // unknown id
    tc(SUB_ENABLE, 16'd999, 16'd0);
    tc(SUB_ENABLE, tracker.ids[7], 16'd0);
    tc(SUB_INTERVAL, tracker.ids[7], 16'd1);
    tick();
    tc(SUB_INTERVAL, tracker.ids[2], 16'hFFFF);
    tc(SUB_DISABLE, tracker.ids[1], 16'd0);
    offer(CMD_UNUSED, SUB_ENABLE, tracker.ids[3], 16'd1, 5'd1, 64'd1);  // ignored
    tick();
    tc(SUB_INTERVAL, tracker.ids[7], 16'd3);
    tick();
    tick();
    tc(SUB_INTERVAL, tracker.ids[7], 16'd1);       // count already past it
    tick();
    tc(SUB_DISABLE, tracker.ids[0], 16'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) tx_gappy = ($urandom_range(0, 2) != 0);
      if (i == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      random_item();
    end
    in_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d transfers in: %0d telecommands, %0d ticks, %0d store writes",
             tracker.taken, tracker.n_tc, tracker.n_tick, tracker.n_store);
    $display("%0d acknowledgements and %0d report items compared, incl. a long output hold",
             tracker.n_acks, tracker.n_reports);
    if (tracker.errors == 0) begin
      $display("housekeeping_report_scheduler_unit regression: pass");
    end else begin
      $display("housekeeping_report_scheduler_unit regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/hrs_pkg.sv
hdl/hrs_param_store.sv
hdl/housekeeping_report_scheduler_unit.sv
test/testbench.sv
